@@ rtl/ogds_pkg.sv @@
// Shared types and constants for the occupancy grid disc stamp and probe block.
// Depends on nothing; the top and ogds_ctrl import it.
`timescale 1ns / 1ps

package ogds_pkg;

  localparam int COORD_W     = 11;
  localparam int RADIUS_W    = 6;
  localparam int DIM_CFG_W   = 9;
  localparam int VALUE_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 63;

  localparam logic [VALUE_W-1:0] OCCUPIED_MARK = 8'd100;

  localparam logic [DIM_CFG_W-1:0] RST_GRID_WIDTH   = 9'd256;
  localparam logic [DIM_CFG_W-1:0] RST_GRID_HEIGHT  = 9'd256;
  localparam logic [RADIUS_W-1:0]  RST_STAMP_RADIUS = 6'd6;
  localparam logic [RADIUS_W-1:0]  RST_PROBE_RADIUS = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_STAMP_RADIUS = 2'd2,
    REG_PROBE_RADIUS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_STAMP = 2'd0,
    REQ_PROBE = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] grid_width;
    logic [DIM_CFG_W-1:0] grid_height;
    logic [RADIUS_W-1:0]  stamp_radius;
    logic [RADIUS_W-1:0]  probe_radius;
  } cfg_regs_t;

endpackage

@@ rtl/occupancy_grid_disc_stamp_probe_top.sv @@
// Occupancy grid disc stamp and probe block: configuration registers and sequencer.
// Depends on ogds_pkg and ogds_ctrl.
// Strobe path after the accepting edge: MUL then CHECK for a write, an invalid address or
// radius 0; a read adds RDWAIT; a disc walk adds WALK over 2r by 2r steps and then DRAIN.
// One transaction at a time; the next is taken at the edge that ends the strobe cycle.
// Reset loads the register defaults and idles the sequencer; the grid is undefined; no stall.
`timescale 1ns / 1ps

module occupancy_grid_disc_stamp_probe_top
  import ogds_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_cell_x,
  input  logic signed [COORD_W-1:0] in_cell_y,
  input  logic                      in_use_default_radius,
  input  logic [RADIUS_W-1:0]       in_radius_cells,
  input  logic signed [VALUE_W-1:0] in_write_value,
  output logic                      out_valid,
  output logic                      out_center_valid,
  output logic                      out_occupied_hit,
  output logic signed [VALUE_W-1:0] out_cell_value_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_regs_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GRID_WIDTH:   cfg_nxt.grid_width   = cfg_data[DIM_CFG_W-1:0];
        REG_GRID_HEIGHT:  cfg_nxt.grid_height  = cfg_data[DIM_CFG_W-1:0];
        REG_STAMP_RADIUS: cfg_nxt.stamp_radius = cfg_data[RADIUS_W-1:0];
        REG_PROBE_RADIUS: cfg_nxt.probe_radius = cfg_data[RADIUS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= RST_GRID_WIDTH;
      cfg_r.grid_height  <= RST_GRID_HEIGHT;
      cfg_r.stamp_radius <= RST_STAMP_RADIUS;
      cfg_r.probe_radius <= RST_PROBE_RADIUS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ogds_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .start              (start),
    .busy               (busy),
    .req_type           (in_req_type),
    .cell_x             (in_cell_x),
    .cell_y             (in_cell_y),
    .use_default_radius (in_use_default_radius),
    .radius_cells       (in_radius_cells),
    .write_value        (in_write_value),
    .out_valid          (out_valid),
    .center_valid       (out_center_valid),
    .occupied_hit       (out_occupied_hit),
    .cell_value_out     (out_cell_value_out)
  );

endmodule

@@ rtl/ogds_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ogds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/ogds_ctrl.sv @@
// Request sequencer: address check, disc walk pipeline and grid memory access.
// Depends on ogds_pkg and ogds_ram.
`timescale 1ns / 1ps

module ogds_ctrl
  import ogds_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_regs_t                 cfg,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic signed [COORD_W-1:0] cell_x,
  input  logic signed [COORD_W-1:0] cell_y,
  input  logic                      use_default_radius,
  input  logic [RADIUS_W-1:0]       radius_cells,
  input  logic signed [VALUE_W-1:0] write_value,
  output logic                      out_valid,
  output logic                      center_valid,
  output logic                      occupied_hit,
  output logic signed [VALUE_W-1:0] cell_value_out
);

  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int D_W    = RAD_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RR_W   = 2 * RAD_W;
  localparam int DC_A   = (WD_W > HT_W) ? WD_W : HT_W;
  localparam int DC_W   = (DC_A > DIM_CFG_W) ? DC_A : DIM_CFG_W;
  localparam int RC_W   = (RAD_W > RADIUS_W) ? RAD_W : RADIUS_W;
  localparam int E_A    = (COORD_W > D_W) ? COORD_W : D_W;
  localparam int E_B    = (E_A > DC_A + 1) ? E_A : DC_A + 1;
  localparam int E_W    = E_B + 1;
  localparam int YM_W   = COORD_W + WD_W + 1;
  localparam int LIN_W  = YM_W + 1;
  localparam int WH_W   = WD_W + HT_W;
  localparam int CMP_W  = (LIN_W > WH_W) ? LIN_W : WH_W;
  localparam int PYW_W  = WD_W + HT_W;
  localparam int ADS_W  = PYW_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RDWAIT = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  req_kind_t                 kind_r, kind_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RAD_W-1:0]          r_r, r_nxt;
  logic [VALUE_W-1:0]        wval_r, wval_nxt;
  logic [WD_W-1:0]           w_r, w_nxt;
  logic [HT_W-1:0]           h_r, h_nxt;
  logic signed [YM_W-1:0]    ym_r, ym_nxt;
  logic [WH_W-1:0]           wh_r, wh_nxt;
  logic [RR_W-1:0]           rr_r, rr_nxt;
  logic signed [D_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic                      v1_r, v1_nxt;
  logic                      inb1_r, inb1_nxt;
  logic [WD_W-1:0]           px1_r, px1_nxt;
  logic [PYW_W-1:0]          pyw1_r, pyw1_nxt;
  logic [SQ_W-1:0]           sqx1_r, sqx1_nxt, sqy1_r, sqy1_nxt;
  logic                      rdv_r, rdv_nxt;
  logic                      hit_r, hit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      cv_r, cv_nxt;
  logic                      ohit_r, ohit_nxt;
  logic [VALUE_W-1:0]        val_r, val_nxt;

  logic [DC_W-1:0]           wsel, hsel;
  logic [RADIUS_W-1:0]       rsel;
  logic [RC_W-1:0]           rclamp;
  logic signed [D_W-1:0]     r_pos, r_neg, r_m1;
  logic signed [E_W-1:0]     px, py;
  logic signed [LIN_W-1:0]   lin;
  logic                      lin_ok;
  logic                      in_disc, op2;
  logic [ADS_W-1:0]          addr_sum;
  logic                      mem_en, mem_we;
  logic [AW-1:0]             mem_addr;
  logic [VALUE_W-1:0]        mem_wdata, mem_rdata;

  ogds_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign center_valid   = cv_r;
  assign occupied_hit   = ohit_r;
  assign cell_value_out = $signed(val_r);

  always_comb begin
    wsel = (DC_W'(cfg.grid_width) > DC_W'(MAX_WIDTH)) ? DC_W'(MAX_WIDTH)
                                                       : DC_W'(cfg.grid_width);
    hsel = (DC_W'(cfg.grid_height) > DC_W'(MAX_HEIGHT)) ? DC_W'(MAX_HEIGHT)
                                                         : DC_W'(cfg.grid_height);
    if (use_default_radius) begin
      rsel = (req_type == REQ_STAMP) ? cfg.stamp_radius : cfg.probe_radius;
    end else begin
      rsel = radius_cells;
    end
    rclamp = (RC_W'(rsel) > RC_W'(MAX_RADIUS)) ? RC_W'(MAX_RADIUS) : RC_W'(rsel);

    r_pos = $signed({1'b0, r_r});
    r_neg = -r_pos;
    r_m1  = r_pos - D_W'(1);

    lin    = LIN_W'(ym_r) + LIN_W'(cx_r);
    lin_ok = !lin[LIN_W-1] && (CMP_W'(lin[LIN_W-2:0]) < CMP_W'(wh_r));

    px = E_W'(cx_r) + E_W'(dx_r);
    py = E_W'(cy_r) + E_W'(dy_r);

    in_disc  = (SUM_W'(sqx1_r) + SUM_W'(sqy1_r)) < SUM_W'(rr_r);
    op2      = v1_r && inb1_r && in_disc;
    addr_sum = ADS_W'(pyw1_r) + ADS_W'(px1_r);
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    r_nxt         = r_r;
    wval_nxt      = wval_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    ym_nxt        = ym_r;
    wh_nxt        = wh_r;
    rr_nxt        = rr_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    hit_nxt       = hit_r | (rdv_r && (mem_rdata == OCCUPIED_MARK));
    out_valid_nxt = 1'b0;
    cv_nxt        = cv_r;
    ohit_nxt      = ohit_r;
    val_nxt       = val_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = AW'(addr_sum);
    mem_wdata     = OCCUPIED_MARK;

    v1_nxt   = (state_r == ST_WALK);
    inb1_nxt = !px[E_W-1] && (px < $signed(E_W'(w_r))) &&
               !py[E_W-1] && (py < $signed(E_W'(h_r)));
    px1_nxt  = px[WD_W-1:0];
    pyw1_nxt = PYW_W'(py[HT_W-1:0]) * PYW_W'(w_r);
    sqx1_nxt = SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy1_nxt = SQ_W'(dy_r) * SQ_W'(dy_r);
    rdv_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = req_kind_t'(req_type);
          cx_nxt    = cell_x;
          cy_nxt    = cell_y;
          r_nxt     = RAD_W'(rclamp);
          wval_nxt  = write_value;
          w_nxt     = WD_W'(wsel);
          h_nxt     = HT_W'(hsel);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ym_nxt    = YM_W'(cy_r) * YM_W'($signed({1'b0, w_r}));
        wh_nxt    = WH_W'(w_r) * WH_W'(h_r);
        rr_nxt    = RR_W'(r_r) * RR_W'(r_r);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        hit_nxt  = 1'b0;
        val_nxt  = '0;
        ohit_nxt = 1'b0;
        cv_nxt   = lin_ok;
        mem_addr = AW'(lin);
        mem_wdata = wval_r;
        if (!lin_ok) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          unique case (kind_r)
            REQ_STAMP, REQ_PROBE: begin
              if (r_r == '0) begin
                out_valid_nxt = 1'b1;
                state_nxt     = ST_IDLE;
              end else begin
                dx_nxt    = r_neg;
                dy_nxt    = r_neg;
                state_nxt = ST_WALK;
              end
            end
            REQ_WRITE: begin
              mem_en        = 1'b1;
              mem_we        = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            REQ_READ: begin
              mem_en    = 1'b1;
              state_nxt = ST_RDWAIT;
            end
          endcase
        end
      end
      ST_WALK: begin
        mem_en  = op2;
        mem_we  = (kind_r == REQ_STAMP);
        rdv_nxt = op2 && (kind_r == REQ_PROBE);
        if (dy_r == r_m1) begin
          dy_nxt = r_neg;
          dx_nxt = dx_r + D_W'(1);
          if (dx_r == r_m1) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          dy_nxt = dy_r + D_W'(1);
        end
      end
      ST_DRAIN: begin
        mem_en  = op2;
        mem_we  = (kind_r == REQ_STAMP);
        rdv_nxt = op2 && (kind_r == REQ_PROBE);
        if (!v1_r && !rdv_r) begin
          ohit_nxt      = (kind_r == REQ_PROBE) && hit_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        val_nxt       = mem_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= v1_nxt;
      rdv_r       <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    r_r    <= r_nxt;
    wval_r <= wval_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    ym_r   <= ym_nxt;
    wh_r   <= wh_nxt;
    rr_r   <= rr_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    inb1_r <= inb1_nxt;
    px1_r  <= px1_nxt;
    pyw1_r <= pyw1_nxt;
    sqx1_r <= sqx1_nxt;
    sqy1_r <= sqy1_nxt;
    hit_r  <= hit_nxt;
    cv_r   <= cv_nxt;
    ohit_r <= ohit_nxt;
    val_r  <= val_nxt;
  end

endmodule
